>>> design/vcs_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcs_pkg
// Shared types and constants of the velocity command shaper.
// ---------------------------------------------------------------------------
package vcs_pkg;

  // operand and result widths of the shared iterative units
  localparam int MUL_W  = 34;
  localparam int PROD_W = 2 * MUL_W;
  localparam int SQ_W   = 64;
  localparam int ROOT_W = SQ_W / 2;

  // translational dead band, Q16.16 LSBs
  localparam logic [31:0] VEL_EPS = 32'd1;

  // configuration register indexes
  localparam logic [2:0] REG_MAX_VEL_X     = 3'd0;
  localparam logic [2:0] REG_MAX_VEL_Y     = 3'd1;
  localparam logic [2:0] REG_MAX_TURN_RATE = 3'd2;
  localparam logic [2:0] REG_MAX_ACC_X     = 3'd3;
  localparam logic [2:0] REG_MAX_ACC_Y     = 3'd4;
  localparam logic [2:0] REG_MAX_ACC_TURN  = 3'd5;
  localparam logic [2:0] REG_CMD_TIMEOUT   = 3'd6;
  localparam logic [2:0] REG_MAX_DT        = 3'd7;

  // input action codes
  localparam logic ACT_COMMAND = 1'b0;
  localparam logic ACT_TICK    = 1'b1;

  typedef struct packed {
    logic               action;
    logic signed [31:0] cmd_vx;
    logic signed [31:0] cmd_vy;
    logic signed [31:0] cmd_turn;
    logic        [31:0] now_time;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_vx;
    logic signed [31:0] out_vy;
    logic signed [31:0] out_turn;
    logic               timed_out;
  } res_item_t;

  // start and completion of one iterative unit
  typedef struct packed {
    logic start;
    logic done;
  } unit_hs_t;

endpackage
`default_nettype wire

>>> design/vcs_mul.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcs_mul
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// ---------------------------------------------------------------------------
module vcs_mul (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [vcs_pkg::MUL_W-1:0]       a,
  input  wire  [vcs_pkg::MUL_W-1:0]       b,
  output logic                            done,
  output logic [vcs_pkg::PROD_W-1:0]      prod
);

  logic [vcs_pkg::PROD_W-1:0] mcand;
  logic [vcs_pkg::MUL_W-1:0]  mplier;
  logic [5:0]                 cnt;
  logic                       busy;

  // load operands, then add one partial product a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        prod   <= '0;
        mcand  <= {{(vcs_pkg::PROD_W - vcs_pkg::MUL_W){1'b0}}, a};
        mplier <= b;
        cnt    <= 6'(vcs_pkg::MUL_W);
        busy   <= 1'b1;
      end else if (busy) begin
        if (mplier[0]) begin
          prod <= prod + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        cnt    <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/vcs_div.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcs_div
// Restoring unsigned divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module vcs_div (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [vcs_pkg::PROD_W-1:0]      dividend,
  input  wire  [vcs_pkg::MUL_W-1:0]       divisor,
  output logic                            done,
  output logic [vcs_pkg::PROD_W-1:0]      quo
);

  logic [vcs_pkg::MUL_W-1:0] dv;
  logic [vcs_pkg::MUL_W:0]   rem;
  logic [vcs_pkg::MUL_W:0]   trial;
  logic [6:0]                cnt;
  logic                      busy;

  assign trial = {rem[vcs_pkg::MUL_W-1:0], quo[vcs_pkg::PROD_W-1]};

  // shift in one dividend bit, subtract where the divisor fits
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        quo  <= dividend;
        dv   <= divisor;
        rem  <= '0;
        cnt  <= 7'(vcs_pkg::PROD_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (trial >= {1'b0, dv}) begin
          rem <= trial - {1'b0, dv};
          quo <= {quo[vcs_pkg::PROD_W-2:0], 1'b1};
        end else begin
          rem <= trial;
          quo <= {quo[vcs_pkg::PROD_W-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/vcs_sqrt.sv
`default_nettype none
// ---------------------------------------------------------------------------
// vcs_sqrt
// Integer square root, one root bit per cycle.
// ---------------------------------------------------------------------------
module vcs_sqrt (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  input  wire  [vcs_pkg::SQ_W-1:0]        val,
  output logic                            done,
  output logic [vcs_pkg::ROOT_W-1:0]      root
);

  logic [vcs_pkg::SQ_W-1:0]   rad;
  logic [vcs_pkg::ROOT_W+1:0] rem;
  logic [vcs_pkg::ROOT_W+2:0] t;
  logic [vcs_pkg::ROOT_W+2:0] trial;
  logic [5:0]                 cnt;
  logic                       busy;

  assign t     = {rem[vcs_pkg::ROOT_W:0], rad[vcs_pkg::SQ_W-1 -: 2]};
  assign trial = {1'b0, root, 2'b01};

  // bring down two radicand bits, try the next root bit
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rad  <= val;
        rem  <= '0;
        root <= '0;
        cnt  <= 6'(vcs_pkg::ROOT_W);
        busy <= 1'b1;
      end else if (busy) begin
        if (t >= trial) begin
          rem  <= vcs_pkg::ROOT_W'(0) + (vcs_pkg::ROOT_W+2)'(t - trial);
          root <= {root[vcs_pkg::ROOT_W-2:0], 1'b1};
        end else begin
          rem  <= (vcs_pkg::ROOT_W+2)'(t);
          root <= {root[vcs_pkg::ROOT_W-2:0], 1'b0};
        end
        rad <= rad << 2;
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

>>> design/velocity_command_shaper_unit.sv
`default_nettype none
// ---------------------------------------------------------------------------
// velocity_command_shaper_unit
// Planar base velocity shaper: command clamp and acceleration-limited ticks.
// ---------------------------------------------------------------------------
// Input channel (in_valid / in_stall / in_item) carries commands and ticks.
// A command clamps the translation to the mean velocity limit and the turn
// rate to its limit, stores it as target and stamps it; it gives no result.
// A tick steps the shaped velocity toward the target within the
// acceleration limits, or zeroes it on command timeout, and gives one
// result on res_valid / res_stall / res_item.
// One item is worked on at a time; in_stall is high until it is done.
// A command works through two squarings, a square root, and a scale and
// divide per axis; when the magnitude is in the dead band it zeroes the
// translation target after the square root. A tick does one to three
// multiplies per axis for the step limit (one for an axis that is not
// limited, three for one that is), then a scale and divide per axis; on
// timeout it goes straight to the output step. The steps share the bit-serial units.
// A finished result waits in the output register while res_stall is high;
// a following tick holds at its end until that register is free.
// Configuration writes (cfg_we, cfg_index, cfg_data) take effect at once.
// Synchronous reset restores the register defaults and zeroes targets, velocity and stamps.
// ---------------------------------------------------------------------------
module velocity_command_shaper_unit (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire vcs_pkg::in_item_t  in_item,
  output logic                 res_valid,
  input  wire                  res_stall,
  output vcs_pkg::res_item_t   res_item,
  input  wire                  cfg_we,
  input  wire  [2:0]           cfg_index,
  input  wire  [31:0]          cfg_data
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_C_SQX  = 4'd1;
  localparam logic [3:0] S_C_SQY  = 4'd2;
  localparam logic [3:0] S_C_SQRT = 4'd3;
  localparam logic [3:0] S_C_MUL  = 4'd4;
  localparam logic [3:0] S_C_DIV  = 4'd5;
  localparam logic [3:0] S_T_BEG  = 4'd6;
  localparam logic [3:0] S_T_MD   = 4'd7;
  localparam logic [3:0] S_T_C1   = 4'd8;
  localparam logic [3:0] S_T_C2   = 4'd9;
  localparam logic [3:0] S_T_SMUL = 4'd10;
  localparam logic [3:0] S_T_SDIV = 4'd11;
  localparam logic [3:0] S_T_OUT  = 4'd12;

  localparam int MW = vcs_pkg::MUL_W;
  localparam int PW = vcs_pkg::PROD_W;

  // configuration
  logic [30:0] max_vel_x, max_vel_y, max_turn_rate;
  logic [30:0] max_acc_x, max_acc_y, max_acc_turn;
  logic [31:0] cmd_timeout, max_dt;

  // state
  logic [3:0]         st;
  logic               issued;
  logic [1:0]         sel;
  vcs_pkg::in_item_t  item;
  logic [63:0]        sum;
  logic [31:0]        mag;
  logic [31:0]        dt;
  logic               to_flag;
  logic signed [31:0] tgt [3];
  logic signed [31:0] cur [3];
  logic signed [32:0] dd  [3];
  logic [31:0]        command_stamp, previous_tick_time;
  logic [MW-1:0]      bn, bd, md;
  logic [PW-1:0]      lhs;

  // unit connections
  wire vcs_pkg::unit_hs_t mul_hs, div_hs, sqrt_hs;
  logic [MW-1:0]      mul_a, mul_b, div_dvs;
  logic [PW-1:0]      prod, quo;
  logic [31:0]        root;

  // helpers
  logic [31:0]        abs_vx, abs_vy, cl, lim32, dt_raw, age;
  logic [32:0]        abs_d;
  logic [47:0]        md_w;
  logic [30:0]        acc_sel;
  logic signed [31:0] tr_clamp, tl, tl_neg;
  logic signed [32:0] step_q;

  assign abs_vx  = item.cmd_vx[31] ? (~item.cmd_vx + 32'd1) : item.cmd_vx;
  assign abs_vy  = item.cmd_vy[31] ? (~item.cmd_vy + 32'd1) : item.cmd_vy;
  assign lim32   = 32'(({1'b0, max_vel_x} + {1'b0, max_vel_y}) >> 1);
  assign cl      = (mag < lim32) ? mag : lim32;
  assign abs_d   = dd[sel][32] ? 33'(-dd[sel]) : 33'(dd[sel]);
  assign md_w    = prod[67:20];
  assign dt_raw  = item.now_time - previous_tick_time;
  assign age     = item.now_time - command_stamp;
  assign step_q  = dd[sel][32] ? -$signed(quo[32:0]) : $signed(quo[32:0]);

  always_comb begin
    case (sel)
      2'd0:    acc_sel = max_acc_x;
      2'd1:    acc_sel = max_acc_y;
      default: acc_sel = max_acc_turn;
    endcase
  end

  // clamp the incoming turn rate
  assign tl     = $signed({1'b0, max_turn_rate});
  assign tl_neg = -tl;
  always_comb begin
    tr_clamp = in_item.cmd_turn;
    if (tr_clamp > tl) begin
      tr_clamp = tl;
    end
    if (tr_clamp < tl_neg) begin
      tr_clamp = tl_neg;
    end
  end

  // route operands to the shared units
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st)
      S_C_SQX: begin
        mul_a = MW'(abs_vx);
        mul_b = MW'(abs_vx);
      end
      S_C_SQY: begin
        mul_a = MW'(abs_vy);
        mul_b = MW'(abs_vy);
      end
      S_C_MUL: begin
        mul_a = sel[0] ? MW'(abs_vy) : MW'(abs_vx);
        mul_b = MW'(cl);
      end
      S_T_MD: begin
        mul_a = MW'(acc_sel);
        mul_b = MW'(dt);
      end
      S_T_C1: begin
        mul_a = md;
        mul_b = bd;
      end
      S_T_C2: begin
        mul_a = bn;
        mul_b = MW'(abs_d);
      end
      S_T_SMUL: begin
        mul_a = MW'(abs_d);
        mul_b = bn;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign div_dvs = (st == S_C_DIV) ? MW'(mag) : bd;

  assign mul_hs.start  = !issued && (st == S_C_SQX || st == S_C_SQY || st == S_C_MUL ||
                                     st == S_T_MD || st == S_T_C1 || st == S_T_C2 ||
                                     st == S_T_SMUL);
  assign div_hs.start  = !issued && (st == S_C_DIV || st == S_T_SDIV);
  assign sqrt_hs.start = !issued && (st == S_C_SQRT);

  vcs_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_hs.start),
    .a     (mul_a),
    .b     (mul_b),
    .done  (mul_hs.done),
    .prod  (prod)
  );

  vcs_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_hs.start),
    .dividend (prod),
    .divisor  (div_dvs),
    .done     (div_hs.done),
    .quo      (quo)
  );

  vcs_sqrt u_sqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sqrt_hs.start),
    .val   (sum),
    .done  (sqrt_hs.done),
    .root  (root)
  );

  assign in_stall = (st != S_IDLE);

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      max_vel_x     <= 31'd32768;
      max_vel_y     <= 31'd32768;
      max_turn_rate <= 31'd655360;
      max_acc_x     <= 31'd13107;
      max_acc_y     <= 31'd13107;
      max_acc_turn  <= 31'd655360;
      cmd_timeout   <= 32'd1048576;
      max_dt        <= 32'd10486;
    end else if (cfg_we) begin
      unique case (cfg_index)
        vcs_pkg::REG_MAX_VEL_X:     max_vel_x     <= cfg_data[30:0];
        vcs_pkg::REG_MAX_VEL_Y:     max_vel_y     <= cfg_data[30:0];
        vcs_pkg::REG_MAX_TURN_RATE: max_turn_rate <= cfg_data[30:0];
        vcs_pkg::REG_MAX_ACC_X:     max_acc_x     <= cfg_data[30:0];
        vcs_pkg::REG_MAX_ACC_Y:     max_acc_y     <= cfg_data[30:0];
        vcs_pkg::REG_MAX_ACC_TURN:  max_acc_turn  <= cfg_data[30:0];
        vcs_pkg::REG_CMD_TIMEOUT:   cmd_timeout   <= cfg_data;
        vcs_pkg::REG_MAX_DT:        max_dt        <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      st                 <= S_IDLE;
      issued             <= 1'b0;
      sel                <= 2'd0;
      res_valid          <= 1'b0;
      command_stamp      <= '0;
      previous_tick_time <= '0;
      for (int i = 0; i < 3; i++) begin
        tgt[i] <= '0;
        cur[i] <= '0;
      end
    end else begin
      // drop the result once taken
      if (res_valid && !res_stall) begin
        res_valid <= 1'b0;
      end
      if (mul_hs.start || div_hs.start || sqrt_hs.start) begin
        issued <= 1'b1;
      end
      unique case (st)
        S_IDLE: begin
          if (in_valid) begin
            item <= in_item;
            if (in_item.action == vcs_pkg::ACT_TICK) begin
              st <= S_T_BEG;
            end else begin
              tgt[2]        <= tr_clamp;
              command_stamp <= in_item.now_time;
              st            <= S_C_SQX;
            end
          end
        end
        S_C_SQX: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            sum    <= prod[63:0];
            st     <= S_C_SQY;
          end
        end
        S_C_SQY: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            sum    <= sum + prod[63:0];
            st     <= S_C_SQRT;
          end
        end
        S_C_SQRT: begin
          if (sqrt_hs.done) begin
            issued <= 1'b0;
            mag    <= root;
            sel    <= 2'd0;
            if (root > vcs_pkg::VEL_EPS) begin
              st <= S_C_MUL;
            end else begin
              tgt[0] <= '0;
              tgt[1] <= '0;
              st     <= S_IDLE;
            end
          end
        end
        S_C_MUL: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            st     <= S_C_DIV;
          end
        end
        S_C_DIV: begin
          if (div_hs.done) begin
            issued <= 1'b0;
            if (sel[0]) begin
              tgt[1] <= item.cmd_vy[31] ? -$signed(quo[31:0]) : $signed(quo[31:0]);
              st     <= S_IDLE;
            end else begin
              tgt[0] <= item.cmd_vx[31] ? -$signed(quo[31:0]) : $signed(quo[31:0]);
              sel    <= 2'd1;
              st     <= S_C_MUL;
            end
          end
        end
        S_T_BEG: begin
          previous_tick_time <= item.now_time;
          dt      <= (dt_raw > max_dt) ? max_dt : dt_raw;
          to_flag <= (age > cmd_timeout);
          if (age > cmd_timeout) begin
            for (int i = 0; i < 3; i++) begin
              cur[i] <= '0;
            end
            st <= S_T_OUT;
          end else begin
            for (int i = 0; i < 3; i++) begin
              dd[i] <= 33'(tgt[i]) - 33'(cur[i]);
            end
            bn  <= MW'(1);
            bd  <= MW'(1);
            sel <= 2'd0;
            st  <= S_T_MD;
          end
        end
        S_T_MD: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            if ({15'd0, abs_d} <= md_w || md_w < 48'(vcs_pkg::VEL_EPS)) begin
              if (sel == 2'd2) begin
                sel <= 2'd0;
                st  <= S_T_SMUL;
              end else begin
                sel <= sel + 2'd1;
              end
            end else begin
              md <= md_w[MW-1:0];
              st <= S_T_C1;
            end
          end
        end
        S_T_C1: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            lhs    <= prod;
            st     <= S_T_C2;
          end
        end
        S_T_C2: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            // keep the smaller fraction
            if (lhs < prod) begin
              bn <= md;
              bd <= MW'(abs_d);
            end
            if (sel == 2'd2) begin
              sel <= 2'd0;
              st  <= S_T_SMUL;
            end else begin
              sel <= sel + 2'd1;
              st  <= S_T_MD;
            end
          end
        end
        S_T_SMUL: begin
          if (mul_hs.done) begin
            issued <= 1'b0;
            st     <= S_T_SDIV;
          end
        end
        S_T_SDIV: begin
          if (div_hs.done) begin
            issued   <= 1'b0;
            cur[sel] <= 32'(33'(cur[sel]) + step_q);
            if (sel == 2'd2) begin
              st <= S_T_OUT;
            end else begin
              sel <= sel + 2'd1;
              st  <= S_T_SMUL;
            end
          end
        end
        S_T_OUT: begin
          // hold until the output register is free
          if (!res_valid || !res_stall) begin
            res_item.out_vx    <= cur[0];
            res_item.out_vy    <= cur[1];
            res_item.out_turn  <= cur[2];
            res_item.timed_out <= to_flag;
            res_valid          <= 1'b1;
            st                 <= S_IDLE;
          end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  // a timed-out result carries zero velocity
  a_timeout_zero: assert property (@(posedge clk) disable iff (rst)
    (res_valid && res_item.timed_out) |->
      (res_item.out_vx == 0 && res_item.out_vy == 0 && res_item.out_turn == 0))
    else $error("timed-out result with nonzero velocity");

  // an accepted transaction keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("block ready right after accepting a transaction");

  // a new result appears only from the output step of a tick
  a_result_from_tick: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(st) == S_T_OUT && $past(item.action) == vcs_pkg::ACT_TICK))
    else $error("result raised outside the tick output step");

endmodule
`default_nettype wire
